// File: rtl/latency_set_statistics_unit_defines.svh
// ----------------------------------------------------------------------------
// Latency set statistics assertion macros
// Shared assertion macros for the latency set statistics unit.
// ----------------------------------------------------------------------------
`ifndef LATENCY_SET_STATISTICS_UNIT_DEFINES_SVH
`define LATENCY_SET_STATISTICS_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define LSS_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lss assertion failed");
`define LSS_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("lss assertion failed");
`else
`define LSS_ASSERT(name, clk, rst_n, prop)
`define LSS_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

// File: rtl/lss_pkg.sv
// ----------------------------------------------------------------------------
// Latency set statistics package
// Shared sizes and the job record passed from the front to the back.
// ----------------------------------------------------------------------------
`default_nettype none
package lss_pkg;
  localparam int unsigned MAX_SAMPLES = 1024;
  localparam int unsigned SAMPLE_W    = 32;
  localparam int unsigned ADDR_W      = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SUM_W       = SAMPLE_W + ADDR_W;
  localparam int unsigned COUNT_OUT_W = 11;
  localparam int unsigned PCT_NUM     = 99;
  localparam int unsigned PCT_DEN     = 100;
  localparam int unsigned RES_W       = $clog2(PCT_DEN);
  localparam int unsigned BIT_W       = $clog2(SAMPLE_W);
  localparam int unsigned STEP_W      = $clog2(SUM_W + 1);

  typedef struct packed {
    logic [SAMPLE_W-1:0] min_ns;
    logic [SAMPLE_W-1:0] max_ns;
    logic [SUM_W-1:0]    sum;
    logic [CNT_W-1:0]    count;
    logic [CNT_W-1:0]    rank;
    logic                dropped;
    logic                bank;
  } job_t;
endpackage
`default_nettype wire

// File: rtl/lss_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module lss_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// File: rtl/lss_front.sv
// ----------------------------------------------------------------------------
// Latency set statistics front end
// Accepts samples, stores them and keeps running min, max, sum and rank.
// ----------------------------------------------------------------------------
`default_nettype none
module lss_front import lss_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [SAMPLE_W-1:0] sample_ns_i,
  input  wire logic                last_sample_i,
  output logic      [1:0]          we_o,
  output logic      [ADDR_W-1:0]   waddr_o,
  output logic      [SAMPLE_W-1:0] wdata_o,
  output logic                     job_valid_o,
  input  wire logic                job_ready_i,
  output job_t                     job_o,
  input  wire logic                rel_valid_i,
  input  wire logic                rel_bank_i
);
  logic [CNT_W-1:0]    count_q, count_d, rank_q, rank_d;
  logic [RES_W-1:0]    res_q, res_d;
  logic [SAMPLE_W-1:0] min_q, min_d, max_q, max_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic                drop_q, drop_d, bank_q, bank_d;
  logic [1:0]          busy_q, busy_d;
  logic                accept, keep;

  assign in_ready_o = !busy_q[bank_q] && job_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign keep       = count_q < CNT_W'(MAX_SAMPLES);
  assign waddr_o    = count_q[ADDR_W-1:0];
  assign wdata_o    = sample_ns_i;
  assign we_o[0]    = accept && keep && !bank_q;
  assign we_o[1]    = accept && keep && bank_q;
  assign job_valid_o = accept && last_sample_i;

  always_comb begin
    min_d   = min_q;
    max_d   = max_q;
    sum_d   = sum_q;
    count_d = count_q;
    rank_d  = rank_q;
    res_d   = res_q;
    drop_d  = drop_q;
    bank_d  = bank_q;
    busy_d  = busy_q;
    if (accept) begin
      if (keep) begin
        if (sample_ns_i < min_q) begin
          min_d = sample_ns_i;
        end
        if (sample_ns_i > max_q) begin
          max_d = sample_ns_i;
        end
        sum_d   = sum_q + SUM_W'(sample_ns_i);
        count_d = count_q + CNT_W'(1);
        if (res_q >= RES_W'(PCT_DEN - PCT_NUM)) begin
          rank_d = rank_q + CNT_W'(1);
          res_d  = res_q - RES_W'(PCT_DEN - PCT_NUM);
        end else begin
          res_d = res_q + RES_W'(PCT_NUM);
        end
      end else begin
        drop_d = 1'b1;
      end
    end
    job_o.min_ns  = min_d;
    job_o.max_ns  = max_d;
    job_o.sum     = sum_d;
    job_o.count   = count_d;
    job_o.rank    = rank_d;
    job_o.dropped = drop_d;
    job_o.bank    = bank_q;
    if (rel_valid_i) begin
      busy_d[rel_bank_i] = 1'b0;
    end
    if (job_valid_o) begin
      busy_d[bank_q] = 1'b1;
      bank_d  = !bank_q;
      min_d   = '1;
      max_d   = '0;
      sum_d   = '0;
      count_d = '0;
      rank_d  = '0;
      res_d   = '0;
      drop_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q   <= '1;
      max_q   <= '0;
      sum_q   <= '0;
      count_q <= '0;
      rank_q  <= '0;
      res_q   <= '0;
      drop_q  <= 1'b0;
      bank_q  <= 1'b0;
      busy_q  <= '0;
    end else begin
      min_q   <= min_d;
      max_q   <= max_d;
      sum_q   <= sum_d;
      count_q <= count_d;
      rank_q  <= rank_d;
      res_q   <= res_d;
      drop_q  <= drop_d;
      bank_q  <= bank_d;
      busy_q  <= busy_d;
    end
  end
endmodule
`default_nettype wire

// File: rtl/lss_queue.sv
// ----------------------------------------------------------------------------
// Latency set statistics job queue
// Two-entry queue of finished sets between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none
module lss_queue import lss_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_valid_i,
  output logic      push_ready_o,
  input  job_t      push_data_i,
  output logic      pop_valid_o,
  input  wire logic pop_ready_i,
  output job_t      pop_data_o
);
  job_t       slot_q [2];
  logic [1:0] fill_q;
  logic       wp_q, rp_q, push, pop;

  assign push_ready_o = fill_q != 2'd2;
  assign pop_valid_o  = fill_q != 2'd0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = slot_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wp_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      wp_q   <= 1'b0;
      rp_q   <= 1'b0;
    end else begin
      if (push) begin
        wp_q <= !wp_q;
      end
      if (pop) begin
        rp_q <= !rp_q;
      end
      fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// File: rtl/lss_back.sv
// ----------------------------------------------------------------------------
// Latency set statistics back end
// Finds the percentile sample bit by bit and divides the sum for the mean.
// ----------------------------------------------------------------------------
`default_nettype none
`include "latency_set_statistics_unit_defines.svh"
module lss_back import lss_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   job_valid_i,
  output logic                        job_ready_o,
  input  job_t                        job_i,
  output logic      [ADDR_W-1:0]      raddr_o,
  input  wire logic [SAMPLE_W-1:0]    rdata0_i,
  input  wire logic [SAMPLE_W-1:0]    rdata1_i,
  output logic                        rel_valid_o,
  output logic                        rel_bank_o,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic      [SAMPLE_W-1:0]    min_ns_o,
  output logic      [SAMPLE_W-1:0]    max_ns_o,
  output logic      [SAMPLE_W-1:0]    mean_ns_o,
  output logic      [SAMPLE_W-1:0]    p99_ns_o,
  output logic      [COUNT_OUT_W-1:0] sample_count_o,
  output logic                        overflowed_o
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]          state_q, state_d;
  job_t                job_q, job_d;
  logic [BIT_W-1:0]    bit_q, bit_d;
  logic [CNT_W-1:0]    idx_q, idx_d, cnt_q, cnt_d, k_q, k_d;
  logic [SAMPLE_W-1:0] pfx_q, pfx_d;
  logic                rd_vld_q, rd_vld_d, sel_done_q, sel_done_d;
  logic [CNT_W-1:0]    rem_q, rem_d;
  logic [SUM_W-1:0]    dvd_q, dvd_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic                out_valid_q, out_valid_d;
  logic [SAMPLE_W-1:0] o_min_q, o_min_d, o_max_q, o_max_d;
  logic [SAMPLE_W-1:0] o_mean_q, o_mean_d, o_p99_q, o_p99_d;
  logic [CNT_W-1:0]    o_cnt_q, o_cnt_d;
  logic                o_ovf_q, o_ovf_d;
  logic [SAMPLE_W-1:0] rdata, hi_mask;
  logic [CNT_W:0]      rem_sh;
  logic                issue, match, qbit;

  assign raddr_o     = idx_q[ADDR_W-1:0];
  assign rdata       = job_q.bank ? rdata1_i : rdata0_i;
  assign hi_mask     = ~({SAMPLE_W{1'b1}} >> (BIT_W'(SAMPLE_W - 1) - bit_q));
  assign match       = (((rdata ^ pfx_q) & hi_mask) == '0) && !rdata[bit_q];
  assign issue       = idx_q < job_q.count;
  assign rem_sh      = {rem_q, dvd_q[SUM_W-1]};
  assign qbit        = rem_sh >= {1'b0, job_q.count};
  assign job_ready_o = state_q == S_IDLE;
  assign rel_bank_o  = job_q.bank;

  assign out_valid_o    = out_valid_q;
  assign min_ns_o       = o_min_q;
  assign max_ns_o       = o_max_q;
  assign mean_ns_o      = o_mean_q;
  assign p99_ns_o       = o_p99_q;
  assign sample_count_o = COUNT_OUT_W'(o_cnt_q);
  assign overflowed_o   = o_ovf_q;

  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    bit_d       = bit_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    k_d         = k_q;
    pfx_d       = pfx_q;
    rd_vld_d    = rd_vld_q;
    sel_done_d  = sel_done_q;
    rem_d       = rem_q;
    dvd_d       = dvd_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && !out_ready_i;
    o_min_d     = o_min_q;
    o_max_d     = o_max_q;
    o_mean_d    = o_mean_q;
    o_p99_d     = o_p99_q;
    o_cnt_d     = o_cnt_q;
    o_ovf_d     = o_ovf_q;
    rel_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          job_d      = job_i;
          bit_d      = BIT_W'(SAMPLE_W - 1);
          idx_d      = '0;
          cnt_d      = '0;
          k_d        = job_i.rank;
          pfx_d      = '0;
          rd_vld_d   = 1'b0;
          sel_done_d = 1'b0;
          rem_d      = '0;
          dvd_d      = job_i.sum;
          step_d     = '0;
          state_d    = S_RUN;
        end
      end
      S_RUN: begin
        if (!sel_done_q) begin
          rd_vld_d = issue;
          if (issue) begin
            idx_d = idx_q + CNT_W'(1);
          end
          if (rd_vld_q && match) begin
            cnt_d = cnt_q + CNT_W'(1);
          end
          if (!issue && !rd_vld_q) begin
            if (k_q >= cnt_q) begin
              pfx_d[bit_q] = 1'b1;
              k_d = k_q - cnt_q;
            end
            cnt_d = '0;
            idx_d = '0;
            if (bit_q == '0) begin
              sel_done_d = 1'b1;
            end else begin
              bit_d = bit_q - BIT_W'(1);
            end
          end
        end
        if (step_q != STEP_W'(SUM_W)) begin
          rem_d  = qbit ? CNT_W'(rem_sh - {1'b0, job_q.count}) : rem_sh[CNT_W-1:0];
          dvd_d  = {dvd_q[SUM_W-2:0], qbit};
          step_d = step_q + STEP_W'(1);
        end
        if (sel_done_q && step_q == STEP_W'(SUM_W)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          o_min_d     = job_q.min_ns;
          o_max_d     = job_q.max_ns;
          o_mean_d    = dvd_q[SAMPLE_W-1:0];
          o_p99_d     = pfx_q;
          o_cnt_d     = job_q.count;
          o_ovf_d     = job_q.dropped;
          rel_valid_o = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rd_vld_q    <= 1'b0;
      sel_done_q  <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_vld_q    <= rd_vld_d;
      sel_done_q  <= sel_done_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q    <= job_d;
    bit_q    <= bit_d;
    idx_q    <= idx_d;
    cnt_q    <= cnt_d;
    k_q      <= k_d;
    pfx_q    <= pfx_d;
    rem_q    <= rem_d;
    dvd_q    <= dvd_d;
    o_min_q  <= o_min_d;
    o_max_q  <= o_max_d;
    o_mean_q <= o_mean_d;
    o_p99_q  <= o_p99_d;
    o_cnt_q  <= o_cnt_d;
    o_ovf_q  <= o_ovf_d;
  end

  `LSS_ASSERT(a_done_complete, clk_i, rst_ni, (state_q == S_DONE) |-> (sel_done_q && step_q == STEP_W'(SUM_W)))
  `LSS_ASSERT(a_rank_in_set, clk_i, rst_ni, (state_q == S_RUN && !sel_done_q) |-> (k_q < job_q.count))
  `LSS_ASSERT(a_out_from_done, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == S_DONE))
  `LSS_ASSERT_ALWAYS(a_release_done, clk_i, rel_valid_o |-> (state_q == S_DONE))
endmodule
`default_nettype wire

// File: rtl/latency_set_statistics_unit.sv
// ----------------------------------------------------------------------------
// Latency set statistics unit
// Collects latency sets and reports min, max, mean, count and 99th percentile.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle and written into one of two sample banks, so
// a new set loads while the previous one is evaluated. After the last sample of
// a set, the percentile is found one bit per pass over the bank read port, and
// the mean divider runs alongside. Input stalls only when both banks hold sets
// still in work.
`default_nettype none
module latency_set_statistics_unit import lss_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [SAMPLE_W-1:0]    sample_ns_i,
  input  wire logic                   last_sample_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic      [SAMPLE_W-1:0]    min_ns_o,
  output logic      [SAMPLE_W-1:0]    max_ns_o,
  output logic      [SAMPLE_W-1:0]    mean_ns_o,
  output logic      [SAMPLE_W-1:0]    p99_ns_o,
  output logic      [COUNT_OUT_W-1:0] sample_count_o,
  output logic                        overflowed_o
);
  logic [1:0]          we;
  logic [ADDR_W-1:0]   waddr, raddr;
  logic [SAMPLE_W-1:0] wdata, rdata0, rdata1;
  logic                push_valid, push_ready, pop_valid, pop_ready;
  logic                rel_valid, rel_bank;
  job_t                push_job, pop_job;

  lss_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .sample_ns_i, .last_sample_i,
    .we_o(we), .waddr_o(waddr), .wdata_o(wdata),
    .job_valid_o(push_valid), .job_ready_i(push_ready), .job_o(push_job),
    .rel_valid_i(rel_valid), .rel_bank_i(rel_bank)
  );

  lss_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_SAMPLES)) u_bank0 (
    .clk_i, .we_i(we[0]), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata0)
  );

  lss_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_SAMPLES)) u_bank1 (
    .clk_i, .we_i(we[1]), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata1)
  );

  lss_queue u_queue (
    .clk_i, .rst_ni,
    .push_valid_i(push_valid), .push_ready_o(push_ready), .push_data_i(push_job),
    .pop_valid_o(pop_valid), .pop_ready_i(pop_ready), .pop_data_o(pop_job)
  );

  lss_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i(pop_valid), .job_ready_o(pop_ready), .job_i(pop_job),
    .raddr_o(raddr), .rdata0_i(rdata0), .rdata1_i(rdata1),
    .rel_valid_o(rel_valid), .rel_bank_o(rel_bank),
    .out_valid_o, .out_ready_i, .min_ns_o, .max_ns_o, .mean_ns_o, .p99_ns_o,
    .sample_count_o, .overflowed_o
  );
endmodule
`default_nettype wire
